// File: sv/gsht_pkg.sv
package gsht_pkg;

    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_REPLACE  = 3'd1;
    localparam logic [2:0] REQ_REMOVE   = 3'd2;
    localparam logic [2:0] REQ_FIND     = 3'd3;
    localparam logic [2:0] REQ_QUERY    = 3'd4;
    localparam logic [2:0] REQ_SHUTDOWN = 3'd5;

    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_SHUTDOWN      = 4'd1;
    localparam logic [3:0] ST_INVALID       = 4'd2;
    localparam logic [3:0] ST_DUPLICATE     = 4'd3;
    localparam logic [3:0] ST_CAPACITY      = 4'd4;
    localparam logic [3:0] ST_UNKNOWN       = 4'd5;
    localparam logic [3:0] ST_STALE         = 4'd6;
    localparam logic [3:0] ST_REV_EXHAUSTED = 4'd7;
    localparam logic [3:0] ST_GEN_EXHAUSTED = 4'd8;

    localparam logic CFG_MAX_ENTRIES     = 1'b0;
    localparam logic CFG_MAX_QUERY_LIMIT = 1'b1;

    localparam int REC_W = 66;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_EVAL,
        S_SH_RD,
        S_SH_WR,
        S_WRNEW,
        S_FIN,
        S_QEND
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] world;
        logic [15:0] owner_id;
        logic [15:0] generation;
        logic [15:0] new_generation;
        logic [1:0]  phase;
        logic [15:0] features;
        logic [1:0]  phase_filter;
        logic [6:0]  result_limit;
        logic        record_ok;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic        record_present;
        logic [15:0] out_world;
        logic [15:0] out_owner;
        logic [15:0] out_generation;
        logic [1:0]  out_phase;
        logic [15:0] out_features;
        logic [63:0] revision;
        logic        has_more;
        logic        last;
    } t_out;

    typedef struct packed {
        logic                we;
        logic [REC_W-1:0]    wdata;
    } t_wr;

endpackage

// File: sv/gsht_ram.sv
module gsht_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         i_clk,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [gsht_pkg::REC_W-1:0]   o_rd_data,
    input  logic [AW-1:0]                i_wr_addr,
    input  gsht_pkg::t_wr                i_wr
);

    logic [gsht_pkg::REC_W-1:0] r_mem [DEPTH];
    logic [gsht_pkg::REC_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr_addr] <= i_wr.wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/generational_sorted_handle_table.sv
// Sorted table of owner records held in one single-port-read, single-port-write
// RAM. One request is handled at a time: in_ready is high only while the
// sequencer is idle and the output register is free. Rejections found from
// the request alone are answered on acceptance. Lookups walk the sorted table
// from entry 0, one registered RAM read per entry, up to the key position;
// register then shifts the tail up and remove shifts it down, a read and a
// write per moved entry. Query scans stored entries until the table ends or
// a match past the limit appears, held by output stalls; one beat per match
// returned (one empty beat if none). No clearing pass is needed after reset.
module generational_sorted_handle_table #(
    parameter int ENTRIES   = 64,
    parameter int QUERY_MAX = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [6:0]       i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gsht_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gsht_pkg::t_out   o_out_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    gsht_pkg::t_state r_state, n_state;
    gsht_pkg::t_in    r_req,   n_req;
    gsht_pkg::t_out   r_out,   n_out;
    logic             r_ov,    n_ov;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx,   n_idx;
    logic [CW-1:0]    r_p,     n_p;
    logic [63:0]      r_rev,   n_rev;
    logic             r_shut,  n_shut;
    logic             r_hit,   n_hit;
    logic             r_gok,   n_gok;
    logic             r_have,  n_have;
    logic [6:0]       r_n,     n_n;
    logic [gsht_pkg::REC_W-1:0] r_rec, n_rec;
    logic [6:0]       r_max_e, r_max_q;

    logic [AW-1:0]    rd_addr, wr_addr;
    logic [gsht_pkg::REC_W-1:0] rd_data;
    gsht_pkg::t_wr    wr;

    logic             can_emit;
    logic             accept;
    logic             imm_fire;
    logic [3:0]       imm_status;
    logic             imm_shut;
    logic [31:0]      rd_ow;
    logic [31:0]      req_ow;
    logic             search_stop;
    logic             scan_end;
    logic             q_match;
    logic             rev_max;
    logic             full;
    logic             ev_emit;
    logic [3:0]       ev_status;
    logic             ev_rec;

    logic             e_fire;
    logic [3:0]       e_status;
    logic             e_present;
    logic [gsht_pkg::REC_W-1:0] e_rec;
    logic [63:0]      e_rev;
    logic             e_more;
    logic             e_last;

    gsht_ram #(.DEPTH(ENTRIES), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    assign can_emit   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == gsht_pkg::S_IDLE) && can_emit;
    assign accept     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign rd_ow       = rd_data[65:34];
    assign req_ow      = {r_req.world, r_req.owner_id};
    assign search_stop = rd_ow >= req_ow;
    assign scan_end    = (r_idx + CW'(1)) == r_count;
    assign rev_max     = &r_rev;
    assign full        = (32'(r_count) >= 32'(r_max_e)) || (32'(r_count) >= 32'(ENTRIES));
    assign q_match     = (rd_data[65:50] == r_req.world)
                      && ((r_req.phase_filter == 2'd0)
                          || (rd_data[17:16] == r_req.phase_filter - 2'd1))
                      && ((rd_data[15:0] & r_req.features) == r_req.features);

    // checks decided from the request beat alone
    always_comb begin
        imm_fire   = 1'b1;
        imm_status = gsht_pkg::ST_OK;
        imm_shut   = 1'b0;
        if (i_in_data.req_type > gsht_pkg::REQ_SHUTDOWN) begin
            imm_status = gsht_pkg::ST_INVALID;
        end else if (i_in_data.req_type == gsht_pkg::REQ_SHUTDOWN) begin
            imm_shut = 1'b1;
        end else if (r_shut) begin
            imm_status = gsht_pkg::ST_SHUTDOWN;
        end else begin
            unique case (i_in_data.req_type)
                gsht_pkg::REQ_REGISTER: begin
                    imm_status = gsht_pkg::ST_INVALID;
                    imm_fire = !i_in_data.record_ok || (i_in_data.phase == 2'd3)
                            || (i_in_data.world == '0) || (i_in_data.owner_id == '0)
                            || (i_in_data.generation == '0);
                end
                gsht_pkg::REQ_REPLACE: begin
                    imm_status = gsht_pkg::ST_INVALID;
                    imm_fire = !i_in_data.record_ok || (i_in_data.phase == 2'd3)
                            || (i_in_data.world == '0) || (i_in_data.owner_id == '0)
                            || (i_in_data.new_generation == '0)
                            || (i_in_data.generation == '0);
                end
                gsht_pkg::REQ_QUERY: begin
                    if (i_in_data.world == '0) begin
                        imm_status = gsht_pkg::ST_INVALID;
                    end else if ((i_in_data.result_limit == '0)
                            || (i_in_data.result_limit > r_max_q)
                            || (i_in_data.result_limit > 7'(QUERY_MAX))) begin
                        imm_status = gsht_pkg::ST_CAPACITY;
                    end else begin
                        imm_fire = 1'b0;
                    end
                end
                default: begin
                    imm_status = gsht_pkg::ST_INVALID;
                    imm_fire = (i_in_data.world == '0) || (i_in_data.owner_id == '0)
                            || (i_in_data.generation == '0);
                end
            endcase
        end
    end

    // outcome once the key position is known
    always_comb begin
        ev_emit   = 1'b0;
        ev_status = gsht_pkg::ST_OK;
        ev_rec    = 1'b0;
        unique case (r_req.req_type)
            gsht_pkg::REQ_REGISTER: begin
                ev_emit = 1'b1;
                if (r_hit) begin
                    ev_status = gsht_pkg::ST_DUPLICATE;
                end else if (full) begin
                    ev_status = gsht_pkg::ST_CAPACITY;
                end else if (rev_max) begin
                    ev_status = gsht_pkg::ST_REV_EXHAUSTED;
                end else begin
                    ev_emit = 1'b0;
                end
            end
            gsht_pkg::REQ_REPLACE: begin
                ev_emit = 1'b1;
                if (!r_hit) begin
                    ev_status = gsht_pkg::ST_UNKNOWN;
                end else if (!r_gok) begin
                    ev_status = gsht_pkg::ST_STALE;
                end else if (&r_req.generation) begin
                    ev_status = gsht_pkg::ST_GEN_EXHAUSTED;
                end else if (r_req.new_generation != r_req.generation + 16'd1) begin
                    ev_status = gsht_pkg::ST_STALE;
                end else if (rev_max) begin
                    ev_status = gsht_pkg::ST_REV_EXHAUSTED;
                end else begin
                    ev_emit = 1'b0;
                end
            end
            gsht_pkg::REQ_REMOVE: begin
                ev_emit = 1'b1;
                if (!r_hit) begin
                    ev_status = gsht_pkg::ST_UNKNOWN;
                end else if (!r_gok) begin
                    ev_status = gsht_pkg::ST_STALE;
                end else if (rev_max) begin
                    ev_status = gsht_pkg::ST_REV_EXHAUSTED;
                end else begin
                    ev_emit = 1'b0;
                end
            end
            default: begin
                ev_emit = 1'b1;
                if (!r_hit) begin
                    ev_status = gsht_pkg::ST_UNKNOWN;
                end else if (!r_gok) begin
                    ev_status = gsht_pkg::ST_STALE;
                end else begin
                    ev_rec = 1'b1;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gsht_pkg::S_IDLE: begin
                if (accept && !imm_fire) begin
                    if (r_count != '0) begin
                        n_state = gsht_pkg::S_RD;
                    end else if (i_in_data.req_type == gsht_pkg::REQ_QUERY) begin
                        n_state = gsht_pkg::S_QEND;
                    end else begin
                        n_state = gsht_pkg::S_EVAL;
                    end
                end
            end
            gsht_pkg::S_RD: n_state = gsht_pkg::S_CMP;
            gsht_pkg::S_CMP: begin
                if (r_req.req_type == gsht_pkg::REQ_QUERY) begin
                    if (can_emit) begin
                        if (q_match && r_have && (r_n == r_req.result_limit)) begin
                            n_state = gsht_pkg::S_IDLE;
                        end else if (scan_end) begin
                            n_state = gsht_pkg::S_QEND;
                        end else begin
                            n_state = gsht_pkg::S_RD;
                        end
                    end
                end else if (search_stop || scan_end) begin
                    n_state = gsht_pkg::S_EVAL;
                end else begin
                    n_state = gsht_pkg::S_RD;
                end
            end
            gsht_pkg::S_EVAL: begin
                if (ev_emit) begin
                    if (can_emit) begin
                        n_state = gsht_pkg::S_IDLE;
                    end
                end else if (r_req.req_type == gsht_pkg::REQ_REGISTER) begin
                    n_state = (r_count > r_p) ? gsht_pkg::S_SH_RD : gsht_pkg::S_WRNEW;
                end else if (r_req.req_type == gsht_pkg::REQ_REPLACE) begin
                    n_state = gsht_pkg::S_WRNEW;
                end else begin
                    n_state = (r_p + CW'(1) < r_count) ? gsht_pkg::S_SH_RD : gsht_pkg::S_FIN;
                end
            end
            gsht_pkg::S_SH_RD: n_state = gsht_pkg::S_SH_WR;
            gsht_pkg::S_SH_WR: begin
                if (r_req.req_type == gsht_pkg::REQ_REGISTER) begin
                    n_state = (r_idx == r_p) ? gsht_pkg::S_WRNEW : gsht_pkg::S_SH_RD;
                end else begin
                    n_state = scan_end ? gsht_pkg::S_FIN : gsht_pkg::S_SH_RD;
                end
            end
            gsht_pkg::S_WRNEW: n_state = gsht_pkg::S_FIN;
            gsht_pkg::S_FIN, gsht_pkg::S_QEND: begin
                if (can_emit) begin
                    n_state = gsht_pkg::S_IDLE;
                end
            end
            default: n_state = gsht_pkg::S_IDLE;
        endcase
    end

    // datapath and result beats
    always_comb begin
        n_req   = r_req;
        n_count = r_count;
        n_idx   = r_idx;
        n_p     = r_p;
        n_rev   = r_rev;
        n_shut  = r_shut;
        n_hit   = r_hit;
        n_gok   = r_gok;
        n_have  = r_have;
        n_n     = r_n;
        n_rec   = r_rec;
        rd_addr = r_idx[AW-1:0];
        wr_addr = r_p[AW-1:0];
        wr.we    = 1'b0;
        wr.wdata = rd_data;
        e_fire    = 1'b0;
        e_status  = gsht_pkg::ST_OK;
        e_present = 1'b0;
        e_rec     = r_rec;
        e_rev     = r_rev;
        e_more    = 1'b0;
        e_last    = 1'b1;
        unique case (r_state)
            gsht_pkg::S_IDLE: begin
                if (accept) begin
                    n_req  = i_in_data;
                    n_idx  = '0;
                    n_p    = '0;
                    n_hit  = 1'b0;
                    n_gok  = 1'b0;
                    n_have = 1'b0;
                    n_n    = '0;
                    if (imm_fire) begin
                        e_fire   = 1'b1;
                        e_status = imm_status;
                        n_shut   = r_shut | imm_shut;
                    end
                end
            end
            gsht_pkg::S_CMP: begin
                if (r_req.req_type == gsht_pkg::REQ_QUERY) begin
                    if (can_emit) begin
                        n_idx = r_idx + CW'(1);
                        if (q_match) begin
                            if (r_have) begin
                                e_fire    = 1'b1;
                                e_present = 1'b1;
                                if (r_n == r_req.result_limit) begin
                                    e_more = 1'b1;
                                end else begin
                                    e_last = 1'b0;
                                    n_rec  = rd_data;
                                    n_n    = r_n + 7'd1;
                                end
                            end else begin
                                n_rec  = rd_data;
                                n_have = 1'b1;
                                n_n    = 7'd1;
                            end
                        end
                    end
                end else if (search_stop) begin
                    n_p   = r_idx;
                    n_hit = rd_ow == req_ow;
                    n_gok = rd_data[33:18] == r_req.generation;
                    n_rec = rd_data;
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_p   = r_count;
                end
            end
            gsht_pkg::S_EVAL: begin
                if (ev_emit) begin
                    e_fire    = can_emit;
                    e_status  = ev_status;
                    e_present = ev_rec;
                end else if (r_req.req_type == gsht_pkg::REQ_REGISTER) begin
                    n_idx = r_count - CW'(1);
                end else begin
                    n_idx = r_p + CW'(1);
                end
            end
            gsht_pkg::S_SH_WR: begin
                wr.we = 1'b1;
                if (r_req.req_type == gsht_pkg::REQ_REGISTER) begin
                    wr_addr = r_idx[AW-1:0] + AW'(1);
                    n_idx   = r_idx - CW'(1);
                end else begin
                    wr_addr = r_idx[AW-1:0] - AW'(1);
                    n_idx   = r_idx + CW'(1);
                end
            end
            gsht_pkg::S_WRNEW: begin
                wr.we    = 1'b1;
                wr.wdata = {r_req.world, r_req.owner_id,
                            (r_req.req_type == gsht_pkg::REQ_REPLACE)
                                ? r_req.new_generation : r_req.generation,
                            r_req.phase, r_req.features};
            end
            gsht_pkg::S_FIN: begin
                if (can_emit) begin
                    e_fire = 1'b1;
                    n_rev  = r_rev + 64'd1;
                    e_rev  = r_rev + 64'd1;
                    if (r_req.req_type == gsht_pkg::REQ_REGISTER) begin
                        n_count = r_count + CW'(1);
                    end else if (r_req.req_type == gsht_pkg::REQ_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            gsht_pkg::S_QEND: begin
                e_fire    = can_emit;
                e_present = r_have;
            end
            default: begin
            end
        endcase

        n_ov  = e_fire || (r_ov && !i_out_ready);
        n_out = r_out;
        if (e_fire) begin
            n_out.status         = e_status;
            n_out.record_present = e_present;
            n_out.out_world      = e_present ? e_rec[65:50] : '0;
            n_out.out_owner      = e_present ? e_rec[49:34] : '0;
            n_out.out_generation = e_present ? e_rec[33:18] : '0;
            n_out.out_phase      = e_present ? e_rec[17:16] : '0;
            n_out.out_features   = e_present ? e_rec[15:0]  : '0;
            n_out.revision       = e_rev;
            n_out.has_more       = e_more;
            n_out.last           = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsht_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_count <= '0;
            r_rev   <= 64'd1;
            r_shut  <= 1'b0;
            r_max_e <= 7'd64;
            r_max_q <= 7'd64;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_shut  <= n_shut;
            if (i_cfg_we) begin
                if (i_cfg_addr == gsht_pkg::CFG_MAX_ENTRIES) begin
                    r_max_e <= i_cfg_data;
                end else begin
                    r_max_q <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_p    <= n_p;
        r_hit  <= n_hit;
        r_gok  <= n_gok;
        r_have <= n_have;
        r_n    <= n_n;
        r_rec  <= n_rec;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(ENTRIES))
        else $error("entry count beyond table depth");

    a_rev_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_rev >= $past(r_rev)))
        else $error("revision went backwards");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> (32'(wr_addr) <= 32'(r_count)))
        else $error("ram write beyond the filled region");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gsht_pkg::S_IDLE) |-> !o_in_ready)
        else $error("input taken while a request is in flight");

endmodule

// File: test/generational_sorted_handle_table_chk.sv
`timescale 1ns / 100ps

module generational_sorted_handle_table_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [6:0]       i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  gsht_pkg::t_in    i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  gsht_pkg::t_out   i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int DEPTH = 64;

    logic [47:0]    rec_key [DEPTH];
    logic [17:0]    rec_pay [DEPTH];
    int             rec_cnt;
    logic [63:0]    tab_rev;
    logic           closing;
    logic [6:0]     lim_entries;
    logic [6:0]     lim_query;
    gsht_pkg::t_out answers [$];
    int             fails;

    assign o_fail_count = fails;
    assign o_pending    = answers.size();

    function automatic gsht_pkg::t_out blank(logic [3:0] st);
        gsht_pkg::t_out r;
        r = '0;
        r.status   = st;
        r.revision = tab_rev;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic gsht_pkg::t_out from_rec(int idx);
        gsht_pkg::t_out r;
        r = blank(gsht_pkg::ST_OK);
        r.last           = 1'b0;
        r.record_present = 1'b1;
        r.out_world      = rec_key[idx][47:32];
        r.out_owner      = rec_key[idx][31:16];
        r.out_generation = rec_key[idx][15:0];
        r.out_phase      = rec_pay[idx][17:16];
        r.out_features   = rec_pay[idx][15:0];
        return r;
    endfunction

    function automatic int key_pos(logic [31:0] okey);
        int i;
        i = 0;
        while (i < rec_cnt && rec_key[i][47:16] < okey) i++;
        return i;
    endfunction

    // returns index, or -status
    function automatic int locate(logic [15:0] w, logic [15:0] o, logic [15:0] g);
        int p;
        if (w == 0 || o == 0 || g == 0) return -int'(gsht_pkg::ST_INVALID);
        p = key_pos({w, o});
        if (p >= rec_cnt || rec_key[p][47:16] != {w, o}) return -int'(gsht_pkg::ST_UNKNOWN);
        if (rec_key[p][15:0] != g) return -int'(gsht_pkg::ST_STALE);
        return p;
    endfunction

    task automatic predict_table(gsht_pkg::t_in d);
        int   p, r, cap, n, i;
        logic bad;
        logic more;
        gsht_pkg::t_out q;
        bad = !d.record_ok || d.phase > 2 || d.world == 0 || d.owner_id == 0;
        if (d.req_type == gsht_pkg::REQ_SHUTDOWN) begin
            closing = 1'b1;
            answers.push_back(blank(gsht_pkg::ST_OK));
        end else if (d.req_type > gsht_pkg::REQ_SHUTDOWN) begin
            answers.push_back(blank(gsht_pkg::ST_INVALID));
        end else if (closing) begin
            answers.push_back(blank(gsht_pkg::ST_SHUTDOWN));
        end else if (d.req_type == gsht_pkg::REQ_REGISTER) begin
            cap = (lim_entries < DEPTH) ? lim_entries : DEPTH;
            p = key_pos({d.world, d.owner_id});
            if (bad || d.generation == 0) answers.push_back(blank(gsht_pkg::ST_INVALID));
            else if (p < rec_cnt && rec_key[p][47:16] == {d.world, d.owner_id})
                answers.push_back(blank(gsht_pkg::ST_DUPLICATE));
            else if (rec_cnt >= cap) answers.push_back(blank(gsht_pkg::ST_CAPACITY));
            else if (tab_rev == '1) answers.push_back(blank(gsht_pkg::ST_REV_EXHAUSTED));
            else begin
                tab_rev++;
                for (i = rec_cnt; i > p; i--) begin
                    rec_key[i] = rec_key[i-1];
                    rec_pay[i] = rec_pay[i-1];
                end
                rec_key[p] = {d.world, d.owner_id, d.generation};
                rec_pay[p] = {d.phase, d.features};
                rec_cnt++;
                answers.push_back(blank(gsht_pkg::ST_OK));
            end
        end else if (d.req_type == gsht_pkg::REQ_REPLACE) begin
            r = locate(d.world, d.owner_id, d.generation);
            if (bad || d.new_generation == 0) answers.push_back(blank(gsht_pkg::ST_INVALID));
            else if (r < 0) answers.push_back(blank(4'(-r)));
            else if (d.generation == 16'hffff)
                answers.push_back(blank(gsht_pkg::ST_GEN_EXHAUSTED));
            else if (d.new_generation != d.generation + 16'd1)
                answers.push_back(blank(gsht_pkg::ST_STALE));
            else if (tab_rev == '1) answers.push_back(blank(gsht_pkg::ST_REV_EXHAUSTED));
            else begin
                tab_rev++;
                rec_key[r] = {d.world, d.owner_id, d.new_generation};
                rec_pay[r] = {d.phase, d.features};
                answers.push_back(blank(gsht_pkg::ST_OK));
            end
        end else if (d.req_type == gsht_pkg::REQ_REMOVE) begin
            r = locate(d.world, d.owner_id, d.generation);
            if (r < 0) answers.push_back(blank(4'(-r)));
            else if (tab_rev == '1) answers.push_back(blank(gsht_pkg::ST_REV_EXHAUSTED));
            else begin
                tab_rev++;
                for (i = r; i + 1 < rec_cnt; i++) begin
                    rec_key[i] = rec_key[i+1];
                    rec_pay[i] = rec_pay[i+1];
                end
                rec_cnt--;
                answers.push_back(blank(gsht_pkg::ST_OK));
            end
        end else if (d.req_type == gsht_pkg::REQ_FIND) begin
            r = locate(d.world, d.owner_id, d.generation);
            if (r < 0) answers.push_back(blank(4'(-r)));
            else begin
                q = from_rec(r);
                q.last = 1'b1;
                answers.push_back(q);
            end
        end else begin
            cap = (lim_query < 64) ? lim_query : 64;
            n = 0;
            more = 1'b0;
            if (d.world == 0) answers.push_back(blank(gsht_pkg::ST_INVALID));
            else if (d.result_limit == 0 || d.result_limit > cap)
                answers.push_back(blank(gsht_pkg::ST_CAPACITY));
            else begin
                for (i = 0; i < rec_cnt; i++) begin
                    if (rec_key[i][47:32] != d.world) continue;
                    if (d.phase_filter != 0 && rec_pay[i][17:16] != d.phase_filter - 2'd1)
                        continue;
                    if ((rec_pay[i][15:0] & d.features) != d.features) continue;
                    if (n == d.result_limit) begin
                        more = 1'b1;
                        break;
                    end
                    answers.push_back(from_rec(i));
                    n++;
                end
                if (n == 0) answers.push_back(blank(gsht_pkg::ST_OK));
                else begin
                    q = answers.pop_back();
                    q.has_more = more;
                    q.last     = 1'b1;
                    answers.push_back(q);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        gsht_pkg::t_out want;
        if (!i_rst_n) begin
            rec_cnt     = 0;
            tab_rev     = 64'd1;
            closing     = 1'b0;
            lim_entries = 7'd64;
            lim_query   = 7'd64;
            fails       = 0;
            answers.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == gsht_pkg::CFG_MAX_ENTRIES) lim_entries = i_cfg_data;
                else lim_query = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (answers.size() == 0) begin
                    if (fails < 10) $display("unexpected beat %p", i_out_data);
                    fails = fails + 1;
                end else begin
                    want = answers.pop_front();
                    if (i_out_data !== want) begin
                        if (fails < 10)
                            $display("mismatch: expected %p actual %p", want, i_out_data);
                        fails = fails + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_table(i_in_data);
        end
    end

endmodule

// File: test/generational_sorted_handle_table_tb.sv
`timescale 1ns / 100ps

module generational_sorted_handle_table_tb;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic           cfg_addr = 1'b0;
    logic [6:0]     cfg_data = '0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    gsht_pkg::t_in  in_data = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    gsht_pkg::t_out out_data;
    int             fail_count;
    int             pending;
    logic           calm = 1'b0;
    logic           hold_off = 1'b0;
    int             cycles = 0;
    logic [15:0]    worlds [4] = '{16'd1, 16'd2, 16'hffff, 16'h8000};
    logic [15:0]    gens [64];

    always #4 i_clk = ~i_clk;

    generational_sorted_handle_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    generational_sorted_handle_table_chk i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("[generational_sorted_handle_table] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                for (n = 0; n < 400; n++) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_beat(gsht_pkg::t_in d);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic mk_send(logic [2:0] rt, logic [15:0] w, logic [15:0] o,
                           logic [15:0] g, logic [15:0] ng);
        gsht_pkg::t_in d;
        d = '0;
        d.req_type = rt; d.world = w; d.owner_id = o;
        d.generation = g; d.new_generation = ng;
        d.phase = 2'($urandom_range(0, 2));
        d.features = 16'($urandom);
        d.phase_filter = 2'($urandom_range(0, 3));
        d.result_limit = 7'($urandom_range(1, 8));
        d.record_ok = 1'b1;
        send_beat(d);
    endtask

    task automatic settle_and_cfg(logic a, logic [6:0] v);
        drain();
        repeat (200) @(posedge i_clk);
        cfg_we <= 1'b1; cfg_addr <= a; cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        gsht_pkg::t_in d;
        logic [127:0]  raw;
        int            k, o, sel;
        for (k = 0; k < count; k++) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            d = raw[$bits(gsht_pkg::t_in)-1:0];
            o = $urandom_range(1, 12);
            sel = $urandom_range(0, 9);
            if (sel < 9) begin
                d.world = worlds[$urandom_range(0, 3)];
                d.owner_id = 16'(o);
                d.record_ok = ($urandom_range(0, 15) != 0);
                d.phase = 2'($urandom_range(0, 2));
                d.req_type = 3'($urandom_range(0, 4));
                d.generation = ($urandom_range(0, 3) != 0) ? gens[o] : 16'($urandom);
                d.new_generation = ($urandom_range(0, 3) != 0) ? d.generation + 16'd1
                                                              : 16'($urandom);
                d.result_limit = 7'($urandom_range(0, 12));
                if ($urandom_range(0, 1)) d.features = d.features & 16'h0101;
            end
            send_beat(d);
            if (d.req_type == gsht_pkg::REQ_REGISTER) gens[o] = d.generation;
            if (d.req_type == gsht_pkg::REQ_REPLACE && d.new_generation == gens[o] + 16'd1)
                gens[o] = d.new_generation;
        end
    endtask

    initial begin
        gsht_pkg::t_in d;
        int            i;
        for (i = 0; i < 64; i++) gens[i] = 16'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed
        mk_send(gsht_pkg::REQ_REGISTER, 16'hffff, 16'hffff, 16'hffff, 16'd0);
        mk_send(gsht_pkg::REQ_REGISTER, 16'd1, 16'd1, 16'd1, 16'd0);
        mk_send(gsht_pkg::REQ_REGISTER, 16'd1, 16'd1, 16'd5, 16'd0);
        mk_send(gsht_pkg::REQ_REGISTER, 16'd0, 16'd3, 16'd1, 16'd0);
        mk_send(gsht_pkg::REQ_REGISTER, 16'd1, 16'd0, 16'd1, 16'd0);
        mk_send(gsht_pkg::REQ_REGISTER, 16'd1, 16'd2, 16'd0, 16'd0);
        d = '0; d.req_type = gsht_pkg::REQ_REGISTER; d.world = 16'd1; d.owner_id = 16'd9;
        d.generation = 16'd1; d.phase = 2'd3; d.record_ok = 1'b1;
        send_beat(d);
        d.phase = 2'd1; d.record_ok = 1'b0;
        send_beat(d);
        mk_send(gsht_pkg::REQ_REPLACE, 16'hffff, 16'hffff, 16'hffff, 16'd0);
        mk_send(gsht_pkg::REQ_REPLACE, 16'hffff, 16'hffff, 16'hffff, 16'd1);
        mk_send(gsht_pkg::REQ_REPLACE, 16'd1, 16'd1, 16'd1, 16'd2);
        mk_send(gsht_pkg::REQ_REPLACE, 16'd1, 16'd1, 16'd1, 16'd3);
        mk_send(gsht_pkg::REQ_REPLACE, 16'd1, 16'd1, 16'd2, 16'd4);
        mk_send(gsht_pkg::REQ_REPLACE, 16'd7, 16'd7, 16'd1, 16'd2);
        mk_send(gsht_pkg::REQ_FIND, 16'd1, 16'd1, 16'd2, 16'd0);
        mk_send(gsht_pkg::REQ_FIND, 16'd1, 16'd1, 16'd1, 16'd0);
        mk_send(gsht_pkg::REQ_FIND, 16'd1, 16'd4, 16'd1, 16'd0);
        d = '0; d.req_type = gsht_pkg::REQ_QUERY; d.world = 16'd1; d.result_limit = 7'd64;
        send_beat(d);
        d.result_limit = 7'd0;  send_beat(d);
        d.result_limit = 7'd65; send_beat(d);
        d.world = 16'd0; d.result_limit = 7'd1; send_beat(d);
        mk_send(gsht_pkg::REQ_REMOVE, 16'd1, 16'd1, 16'd2, 16'd0);
        mk_send(gsht_pkg::REQ_REMOVE, 16'd1, 16'd1, 16'd2, 16'd0);
        d = '1; d.req_type = 3'd7; send_beat(d);
        d.req_type = 3'd6; send_beat(d);
        gens[1] = 16'd1;
        for (i = 2; i < 64; i++) gens[i] = 16'd1;
        // fill, then long receiver stall with a query backlog
        for (i = 1; i <= 12; i++)
            mk_send(gsht_pkg::REQ_REGISTER, 16'd2, 16'(i), 16'd1, 16'd0);
        hold_off = 1'b1;
        for (i = 0; i < 6; i++) begin
            d = '0; d.req_type = gsht_pkg::REQ_QUERY; d.world = 16'd2;
            d.result_limit = 7'd64;
            send_beat(d);
        end
        random_phase(25);
        settle_and_cfg(gsht_pkg::CFG_MAX_ENTRIES, 7'd3);
        settle_and_cfg(gsht_pkg::CFG_MAX_QUERY_LIMIT, 7'd1);
        random_phase(15);
        settle_and_cfg(gsht_pkg::CFG_MAX_ENTRIES, 7'd0);
        settle_and_cfg(gsht_pkg::CFG_MAX_QUERY_LIMIT, 7'd127);
        random_phase(15);
        settle_and_cfg(gsht_pkg::CFG_MAX_ENTRIES, 7'd127);
        settle_and_cfg(gsht_pkg::CFG_MAX_QUERY_LIMIT, 7'd5);
        random_phase(15);
        calm = 1'b1;
        random_phase(12);
        mk_send(gsht_pkg::REQ_SHUTDOWN, 16'd0, 16'd0, 16'd0, 16'd0);
        mk_send(gsht_pkg::REQ_FIND, 16'd2, 16'd1, 16'd1, 16'd0);
        d = '0; d.req_type = gsht_pkg::REQ_QUERY; d.world = 16'd2; d.result_limit = 7'd1;
        send_beat(d);
        mk_send(gsht_pkg::REQ_SHUTDOWN, 16'd0, 16'd0, 16'd0, 16'd0);
        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[generational_sorted_handle_table] OK");
        end else begin
            $display("[generational_sorted_handle_table] ERROR");
        end
        $finish;
    end

endmodule
